// File: sv/nmd_pkg.sv
// ----------------------------------------------------------------------------
// nmd_pkg
// Shared types and constants of the 3x3 neighbour max dilation block.
// ----------------------------------------------------------------------------
`default_nettype none

package nmd_pkg;

  localparam int CfgW   = 11;
  localparam int PixW   = 32;
  localparam int CoordW = 10;
  localparam int ByteW  = 8;

  localparam logic [CfgW-1:0] WidthReset  = CfgW'(640);
  localparam logic [CfgW-1:0] HeightReset = CfgW'(480);
  localparam logic [PixW-ByteW-1:0] InteriorTop = 24'hFF0000;

  typedef enum logic [0:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_in;
    logic            frame_start;
  } in_req_t;

  typedef struct packed {
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [PixW-1:0]   pixel_out;
    logic              last;
  } out_rsp_t;

endpackage

`default_nettype wire

// File: sv/neighbour_max_dilation_3x3.sv
// ----------------------------------------------------------------------------
// neighbour_max_dilation_3x3
// 3x3 max filter over a raster-order ARGB stream, centre pixel excluded.
// ----------------------------------------------------------------------------
// Requests arrive on in_req_i under in_valid_i/in_ready_o, one pixel each, in
// raster order; frame_start marks pixel (0,0). Results leave on out_rsp_o
// under out_valid_o/out_ready_i. A border pixel is returned unchanged; an
// interior pixel is returned as 0xFF0000MM when its lower-right neighbour
// arrives. A request yields zero, one or two results, last set on its final
// one. Frame size is set through cfg_we_i/cfg_idx_i/cfg_data_i while idle;
// the user must keep to this, as the block does not enforce it.
// Throughput: one request per cycle while in_ready_o is high; the two line
// buffers share one RAM entry per column, read on accept and written back on
// commit, with forwarding when the same column is hit on consecutive requests.
// A request is registered in the accept stage, then committed into the
// result queue driving out_rsp_o, which drains one result at a time. When
// the receiver stalls, the four-entry queue fills; once it holds more than
// two results, commits stop and in_ready_o drops.
// Reset clears counters, window and queue; frame size returns to 640x480.
// Line buffer contents are undefined until the first rows are streamed.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbour_max_dilation_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire nmd_pkg::in_req_t               in_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output nmd_pkg::out_rsp_t                   out_rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [nmd_pkg::CfgW-1:0]       cfg_data_i
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int RowW  = $clog2(MAX_HEIGHT);
  localparam int WDimW = $clog2(MAX_WIDTH + 1);
  localparam int HDimW = $clog2(MAX_HEIGHT + 1);
  localparam int WExtW = (nmd_pkg::CfgW > WDimW) ? nmd_pkg::CfgW : WDimW;
  localparam int HExtW = (nmd_pkg::CfgW > HDimW) ? nmd_pkg::CfgW : HDimW;
  localparam int BW    = nmd_pkg::ByteW;
  localparam int CW    = nmd_pkg::CoordW;

  // configuration
  logic [nmd_pkg::CfgW-1:0] img_w_q, img_h_q;
  logic [WExtW-1:0] w_ext;
  logic [HExtW-1:0] h_ext;
  logic [WDimW-1:0] w_dim;
  logic [HDimW-1:0] h_dim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= nmd_pkg::WidthReset;
      img_h_q <= nmd_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (nmd_pkg::cfg_reg_e'(cfg_idx_i))
        nmd_pkg::CfgImageWidth:  img_w_q <= cfg_data_i;
        nmd_pkg::CfgImageHeight: img_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = WExtW'(img_w_q);
    h_ext = HExtW'(img_h_q);
    if (w_ext == '0) begin
      w_dim = WDimW'(1);
    end else if (w_ext > WExtW'(MAX_WIDTH)) begin
      w_dim = WDimW'(MAX_WIDTH);
    end else begin
      w_dim = w_ext[WDimW-1:0];
    end
    if (h_ext == '0) begin
      h_dim = HDimW'(1);
    end else if (h_ext > HExtW'(MAX_HEIGHT)) begin
      h_dim = HDimW'(MAX_HEIGHT);
    end else begin
      h_dim = h_ext[HDimW-1:0];
    end
  end

  // accept stage: counters and emit decisions
  logic            accept, commit;
  logic [ColW-1:0] col_q, col_d, col;
  logic [RowW-1:0] row_q, row_d, row;
  logic [WDimW-1:0] col_p1;
  logic [HDimW-1:0] row_p1;
  logic            emit_int, emit_bdr;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    col    = in_req_i.frame_start ? '0 : col_q;
    row    = in_req_i.frame_start ? '0 : row_q;
    col_p1 = WDimW'(col) + WDimW'(1);
    row_p1 = HDimW'(row) + HDimW'(1);
    emit_int = (col >= ColW'(2)) && (row >= RowW'(2)) &&
               (col_p1 <= w_dim) && (row_p1 <= h_dim);
    emit_bdr = (col == '0) || (row == '0) || (col_p1 >= w_dim) || (row_p1 >= h_dim);
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_p1 >= w_dim) begin
        col_d = '0;
        row_d = (row_p1 >= h_dim) ? '0 : row + RowW'(1);
      end else begin
        col_d = col + ColW'(1);
        row_d = row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line buffers: {older, newer} byte per column
  logic [2*BW-1:0] ram_rdata, ram_wdata;
  logic [BW-1:0]   older_rd, newer_rd, cur;

  logic                          s1_valid_q;
  logic [ColW-1:0]               s1_idx_q;
  logic [nmd_pkg::PixW-1:0]      s1_pix_q;
  logic [CW-1:0]                 s1_bx_q, s1_by_q, s1_ix_q, s1_iy_q;
  logic                          s1_int_q, s1_bdr_q;
  logic                          fwd_q;
  logic [2*BW-1:0]               fwd_data_q;
  logic                          outq_room;

  nmd_ram #(
    .Width (2 * BW),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (s1_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (ram_rdata)
  );

  assign commit     = s1_valid_q && outq_room;
  assign in_ready_o = !s1_valid_q || commit;

  always_comb begin
    older_rd  = fwd_q ? fwd_data_q[2*BW-1:BW] : ram_rdata[2*BW-1:BW];
    newer_rd  = fwd_q ? fwd_data_q[BW-1:0]    : ram_rdata[BW-1:0];
    cur       = s1_pix_q[BW-1:0];
    ram_wdata = {newer_rd, cur};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= commit && (s1_idx_q == col);
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q   <= col;
      s1_pix_q   <= in_req_i.pixel_in;
      s1_bx_q    <= CW'(col);
      s1_by_q    <= CW'(row);
      s1_ix_q    <= CW'(col - ColW'(1));
      s1_iy_q    <= CW'(row - RowW'(1));
      s1_int_q   <= emit_int;
      s1_bdr_q   <= emit_bdr;
      fwd_data_q <= ram_wdata;
    end
  end

  // 3x3 window and neighbour max
  logic [BW-1:0] win_q [9];
  logic [BW-1:0] nbr [8];
  logic [BW-1:0] nmax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (commit) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= older_rd;
      win_q[5] <= newer_rd;
      win_q[8] <= cur;
    end
  end

  always_comb begin
    nbr[0] = win_q[1];
    nbr[1] = win_q[2];
    nbr[2] = older_rd;
    nbr[3] = win_q[4];
    nbr[4] = newer_rd;
    nbr[5] = win_q[7];
    nbr[6] = win_q[8];
    nbr[7] = cur;
    nmax = '0;
    for (int i = 0; i < 8; i++) begin
      if (nbr[i] > nmax) begin
        nmax = nbr[i];
      end
    end
  end

  // result assembly
  nmd_pkg::out_rsp_t rsp_int, rsp_bdr, push0, push1;
  logic [1:0]        push_n;

  always_comb begin
    rsp_int.out_x     = s1_ix_q;
    rsp_int.out_y     = s1_iy_q;
    rsp_int.pixel_out = {nmd_pkg::InteriorTop, nmax};
    rsp_int.last      = !s1_bdr_q;
    rsp_bdr.out_x     = s1_bx_q;
    rsp_bdr.out_y     = s1_by_q;
    rsp_bdr.pixel_out = s1_pix_q;
    rsp_bdr.last      = 1'b1;
    push0  = s1_int_q ? rsp_int : rsp_bdr;
    push1  = rsp_bdr;
    push_n = commit ? (2'(s1_int_q) + 2'(s1_bdr_q)) : 2'd0;
  end

  nmd_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (push0),
    .push1_i  (push1),
    .room_o   (outq_room),
    .valid_o  (out_valid_o),
    .data_o   (out_rsp_o),
    .ready_i  (out_ready_i)
  );

endmodule

`default_nettype wire

// File: sv/nmd_ram.sv
// ----------------------------------------------------------------------------
// nmd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nmd_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/nmd_outq.sv
// ----------------------------------------------------------------------------
// nmd_outq
// Four-entry result queue; takes up to two results per cycle, drains one while ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module nmd_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        push_n_i,
  input  wire nmd_pkg::out_rsp_t push0_i,
  input  wire nmd_pkg::out_rsp_t push1_i,
  output logic                   room_o,
  output logic                   valid_o,
  output nmd_pkg::out_rsp_t      data_o,
  input  wire logic              ready_i
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  nmd_pkg::out_rsp_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_n_i);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_n_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push1_i;
    end
  end

endmodule

`default_nettype wire
